### design/ldd_pkg.sv
// shared constants for the lock graph deadlock detector
// depends on nothing; used by the interfaces and all modules but ldd_ram
package ldd_pkg;

   localparam int MAX_THREADS = 16;
   localparam int MAX_MUTEXES = 16;
   localparam int NUM_VERTS   = MAX_THREADS + MAX_MUTEXES;
   localparam int SCAN_DEPTH  = (MAX_THREADS > MAX_MUTEXES) ? MAX_THREADS : MAX_MUTEXES;

   localparam int OP_W     = 2;
   localparam int ID_W     = 64;
   localparam int T_SLOT_W = $clog2(MAX_THREADS);
   localparam int M_SLOT_W = $clog2(MAX_MUTEXES);
   localparam int T_CNT_W  = $clog2(MAX_THREADS + 1);
   localparam int M_CNT_W  = $clog2(MAX_MUTEXES + 1);
   localparam int SCAN_W   = $clog2(SCAN_DEPTH + 1);
   localparam int VERT_W   = $clog2(NUM_VERTS);

   localparam logic [OP_W-1:0] OP_UNLOCK   = 2'd0;
   localparam logic [OP_W-1:0] OP_REQUEST  = 2'd1;
   localparam logic [OP_W-1:0] OP_ACQUIRED = 2'd2;

endpackage

### design/ldd_if.sv
// valid/ready channels for lock events and detector results
// depends on ldd_pkg for payload widths
interface ldd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ldd_pkg::OP_W-1:0]     op;
   logic [ldd_pkg::ID_W-1:0]     thread_id;
   logic [ldd_pkg::ID_W-1:0]     mutex_addr;

   modport source (output valid, output op, output thread_id, output mutex_addr,
                   input ready);
   modport sink   (input valid, input op, input thread_id, input mutex_addr,
                   output ready);
endinterface

interface ldd_rsp_if;
   logic valid;
   logic ready;
   logic deadlock;
   logic overflow;

   modport source (output valid, output deadlock, output overflow, input ready);
   modport sink   (input valid, input deadlock, input overflow, output ready);
endinterface

### design/ldd_ram.sv
// generic single write port, single read port ram with registered read
// no package dependencies
module ldd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lock_graph_deadlock_detector.sv
// top level of the lock graph deadlock detector
// depends on ldd_pkg, ldd_if (ldd_req_if, ldd_rsp_if) and ldd_ram
//
// Each req item is one lock event (op, thread id, mutex address) and gives exactly one
// rsp item (deadlock, overflow). Items are handled one at a time. An item first scans the
// thread and mutex id tables together through their ram read ports, one entry per cycle.
// A new id is then added, or overflow is reported if its table is full. The edge matrix
// sits in a 32-row ram; each edge change is a read-modify-write of one row (unlock and
// request make one change, acquire two). After a request the wait-for walk reads one
// row per step, for up to 32 steps. A new item can be taken in the cycle in which the
// last result appears. A finished result waits in the rsp register while the next item
// is taken. Rows have valid bits, so reset and the clear after a deadlock report take
// effect at once with no clearing pass.
module lock_graph_deadlock_detector (
   input logic          clock,
   input logic          reset,
   ldd_req_if.sink      req_ch,
   ldd_rsp_if.source    rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DECIDE, ST_EREAD, ST_EMOD, ST_WREAD, ST_WNEXT, ST_DONE
   } state_type;

   localparam int NV = ldd_pkg::NUM_VERTS;

   // lowest set bit of an edge row
   function automatic logic [ldd_pkg::VERT_W-1:0] lowest_bit(input logic [NV-1:0] row);
      logic [ldd_pkg::VERT_W-1:0] idx;
      idx = '0;
      for (int j = NV - 1; j >= 0; j--) begin
         if (row[j]) begin
            idx = ldd_pkg::VERT_W'(j);
         end
      end
      return idx;
   endfunction

   // count widths brought to the scan index width for compares
   function automatic logic [ldd_pkg::SCAN_W-1:0] SCAN_W_T(
      input logic [ldd_pkg::T_CNT_W-1:0] c);
      return ldd_pkg::SCAN_W'(c);
   endfunction

   function automatic logic [ldd_pkg::SCAN_W-1:0] SCAN_W_M(
      input logic [ldd_pkg::M_CNT_W-1:0] c);
      return ldd_pkg::SCAN_W'(c);
   endfunction

   state_type state_ff, state_in;

   // latched item
   logic [ldd_pkg::OP_W-1:0]  op_ff, op_in;
   logic [ldd_pkg::ID_W-1:0]  tid_ff, tid_in;
   logic [ldd_pkg::ID_W-1:0]  addr_ff, addr_in;

   // table fill counts
   logic [ldd_pkg::T_CNT_W-1:0] thread_count_ff, thread_count_in;
   logic [ldd_pkg::M_CNT_W-1:0] mutex_count_ff, mutex_count_in;

   // lookup scan pipeline
   logic [ldd_pkg::SCAN_W-1:0]  scan_ff, scan_in;
   logic [ldd_pkg::SCAN_W-1:0]  probe_ff, probe_in;
   logic                        probe_vld_ff, probe_vld_in;
   logic                        t_found_ff, t_found_in;
   logic                        m_found_ff, m_found_in;
   logic [ldd_pkg::T_SLOT_W-1:0] t_slot_ff, t_slot_in;
   logic [ldd_pkg::M_SLOT_W-1:0] m_slot_ff, m_slot_in;

   // vertices of this item and edge read-modify-write control
   logic [ldd_pkg::VERT_W-1:0] tv_ff, tv_in;
   logic [ldd_pkg::VERT_W-1:0] mv_ff, mv_in;
   logic [ldd_pkg::VERT_W-1:0] rmw_row_ff, rmw_row_in;
   logic [ldd_pkg::VERT_W-1:0] rmw_col_ff, rmw_col_in;
   logic                       rmw_set_ff, rmw_set_in;
   logic                       second_ff, second_in;
   logic [NV-1:0]              row_vld_ff, row_vld_in;

   // walk state
   logic [ldd_pkg::VERT_W-1:0] cur_ff, cur_in;
   logic [NV-1:0]              marks_ff, marks_in;

   // result of the item in flight and the rsp register
   logic res_dl_ff, res_dl_in;
   logic res_ovf_ff, res_ovf_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_dl_ff, rsp_dl_in;
   logic rsp_ovf_ff, rsp_ovf_in;

   // ram ports
   logic                          t_wr_en, m_wr_en, e_wr_en;
   logic [ldd_pkg::T_SLOT_W-1:0]  t_wr_addr, t_rd_addr;
   logic [ldd_pkg::M_SLOT_W-1:0]  m_wr_addr, m_rd_addr;
   logic [ldd_pkg::ID_W-1:0]      t_rd_data, m_rd_data;
   logic [ldd_pkg::VERT_W-1:0]    e_addr_rd;
   logic [NV-1:0]                 e_rd_data, e_wr_data, e_row;

   ldd_ram #(.WIDTH(ldd_pkg::ID_W), .DEPTH(ldd_pkg::MAX_THREADS)) u_thread_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (tid_ff),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   ldd_ram #(.WIDTH(ldd_pkg::ID_W), .DEPTH(ldd_pkg::MAX_MUTEXES)) u_mutex_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (addr_ff),
      .rd_addr (m_rd_addr),
      .rd_data (m_rd_data)
   );

   ldd_ram #(.WIDTH(NV), .DEPTH(NV)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (rmw_row_ff),
      .wr_data (e_wr_data),
      .rd_addr (e_addr_rd),
      .rd_data (e_rd_data)
   );

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.deadlock = rsp_dl_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

   // both tables are scanned with one index; wider index wraps harmlessly, counts gate it
   assign t_rd_addr = scan_ff[ldd_pkg::T_SLOT_W-1:0];
   assign m_rd_addr = scan_ff[ldd_pkg::M_SLOT_W-1:0];
   assign t_wr_addr = thread_count_ff[ldd_pkg::T_SLOT_W-1:0];
   assign m_wr_addr = mutex_count_ff[ldd_pkg::M_SLOT_W-1:0];

   // edge row read: rmw row in read state, walk vertex otherwise
   assign e_addr_rd = (state_ff == ST_EREAD) ? rmw_row_ff : cur_ff;

   // a row never written since the last clear reads as no edges
   always_comb begin
      e_row = '0;
      if (state_ff == ST_EMOD) begin
         e_row = row_vld_ff[rmw_row_ff] ? e_rd_data : '0;
      end else begin
         e_row = row_vld_ff[cur_ff] ? e_rd_data : '0;
      end
   end

   always_comb begin
      logic [NV-1:0]              col_bit;
      logic [NV-1:0]              nxt_bit;
      logic [ldd_pkg::VERT_W-1:0] nxt;
      logic                       t_new, m_new, ovf;

      state_in        = state_ff;
      op_in           = op_ff;
      tid_in          = tid_ff;
      addr_in         = addr_ff;
      thread_count_in = thread_count_ff;
      mutex_count_in  = mutex_count_ff;
      scan_in         = scan_ff;
      probe_in        = scan_ff;
      probe_vld_in    = 1'b0;
      t_found_in      = t_found_ff;
      m_found_in      = m_found_ff;
      t_slot_in       = t_slot_ff;
      m_slot_in       = m_slot_ff;
      tv_in           = tv_ff;
      mv_in           = mv_ff;
      rmw_row_in      = rmw_row_ff;
      rmw_col_in      = rmw_col_ff;
      rmw_set_in      = rmw_set_ff;
      second_in       = second_ff;
      row_vld_in      = row_vld_ff;
      cur_in          = cur_ff;
      marks_in        = marks_ff;
      res_dl_in       = res_dl_ff;
      res_ovf_in      = res_ovf_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_dl_in       = rsp_dl_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      t_wr_en         = 1'b0;
      m_wr_en         = 1'b0;
      e_wr_en         = 1'b0;
      e_wr_data       = '0;

      col_bit = NV'(1) << rmw_col_ff;
      nxt     = lowest_bit(e_row);
      nxt_bit = NV'(1) << nxt;
      t_new   = !t_found_ff;
      m_new   = !m_found_ff;
      ovf     = (t_new && (thread_count_ff >= ldd_pkg::T_CNT_W'(ldd_pkg::MAX_THREADS))) ||
                (m_new && (mutex_count_ff >= ldd_pkg::M_CNT_W'(ldd_pkg::MAX_MUTEXES)));

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // compare the entry read last cycle; only the first live match counts
      if (probe_vld_ff) begin
         if (!t_found_ff && (probe_ff < SCAN_W_T(thread_count_ff)) && (t_rd_data == tid_ff)) begin
            t_found_in = 1'b1;
            t_slot_in  = probe_ff[ldd_pkg::T_SLOT_W-1:0];
         end
         if (!m_found_ff && (probe_ff < SCAN_W_M(mutex_count_ff)) && (m_rd_data == addr_ff)) begin
            m_found_in = 1'b1;
            m_slot_in  = probe_ff[ldd_pkg::M_SLOT_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in      = req_ch.op;
               tid_in     = req_ch.thread_id;
               addr_in    = req_ch.mutex_addr;
               scan_in    = '0;
               t_found_in = 1'b0;
               m_found_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == ldd_pkg::SCAN_W'(ldd_pkg::SCAN_DEPTH)) begin
               state_in = ST_DECIDE;
            end else begin
               probe_vld_in = 1'b1;
               scan_in      = scan_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            res_dl_in  = 1'b0;
            res_ovf_in = ovf;
            if (ovf) begin
               state_in = ST_DONE;
            end else begin
               if (t_new) begin
                  t_wr_en         = 1'b1;
                  thread_count_in = thread_count_ff + 1'b1;
                  tv_in           = ldd_pkg::VERT_W'(thread_count_ff);
               end else begin
                  tv_in = ldd_pkg::VERT_W'(t_slot_ff);
               end
               if (m_new) begin
                  m_wr_en        = 1'b1;
                  mutex_count_in = mutex_count_ff + 1'b1;
                  mv_in = ldd_pkg::VERT_W'(ldd_pkg::MAX_THREADS) +
                          ldd_pkg::VERT_W'(mutex_count_ff);
               end else begin
                  mv_in = ldd_pkg::VERT_W'(ldd_pkg::MAX_THREADS) + ldd_pkg::VERT_W'(m_slot_ff);
               end
               second_in = 1'b0;
               case (op_ff)
                  ldd_pkg::OP_UNLOCK: begin
                     rmw_row_in = mv_in;
                     rmw_col_in = tv_in;
                     rmw_set_in = 1'b0;
                  end
                  ldd_pkg::OP_REQUEST: begin
                     rmw_row_in = tv_in;
                     rmw_col_in = mv_in;
                     rmw_set_in = 1'b1;
                  end
                  default: begin
                     // acquired, and the unused code: drop the request edge, add holder edge
                     rmw_row_in = tv_in;
                     rmw_col_in = mv_in;
                     rmw_set_in = 1'b0;
                     second_in  = 1'b1;
                  end
               endcase
               state_in = ST_EREAD;
            end
         end
         ST_EREAD: begin
            state_in = ST_EMOD;
         end
         ST_EMOD: begin
            e_wr_en   = 1'b1;
            e_wr_data = rmw_set_ff ? (e_row | col_bit) : (e_row & ~col_bit);
            row_vld_in[rmw_row_ff] = 1'b1;
            if (second_ff) begin
               second_in  = 1'b0;
               rmw_row_in = mv_ff;
               rmw_col_in = tv_ff;
               rmw_set_in = 1'b1;
               state_in   = ST_EREAD;
            end else if (op_ff == ldd_pkg::OP_REQUEST) begin
               cur_in   = tv_ff;
               marks_in = NV'(1) << tv_ff;
               state_in = ST_WREAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WREAD: begin
            state_in = ST_WNEXT;
         end
         ST_WNEXT: begin
            if (e_row == '0) begin
               state_in = ST_DONE;
            end else if ((marks_ff & nxt_bit) != '0) begin
               // wait cycle closed: report and forget everything
               res_dl_in       = 1'b1;
               thread_count_in = '0;
               mutex_count_in  = '0;
               row_vld_in      = '0;
               marks_in        = '0;
               state_in        = ST_DONE;
            end else begin
               marks_in = marks_ff | nxt_bit;
               cur_in   = nxt;
               state_in = ST_WREAD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dl_in    = res_dl_ff;
               rsp_ovf_in   = res_ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload registers, no reset needed
      op_ff      <= op_in;
      tid_ff     <= tid_in;
      addr_ff    <= addr_in;
      scan_ff    <= scan_in;
      probe_ff   <= probe_in;
      t_found_ff <= t_found_in;
      m_found_ff <= m_found_in;
      t_slot_ff  <= t_slot_in;
      m_slot_ff  <= m_slot_in;
      tv_ff      <= tv_in;
      mv_ff      <= mv_in;
      rmw_row_ff <= rmw_row_in;
      rmw_col_ff <= rmw_col_in;
      rmw_set_ff <= rmw_set_in;
      cur_ff     <= cur_in;
      res_dl_ff  <= res_dl_in;
      res_ovf_ff <= res_ovf_in;
      rsp_dl_ff  <= rsp_dl_in;
      rsp_ovf_ff <= rsp_ovf_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         thread_count_ff <= '0;
         mutex_count_ff  <= '0;
         row_vld_ff      <= '0;
         probe_vld_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         second_ff       <= 1'b0;
         marks_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         thread_count_ff <= thread_count_in;
         mutex_count_ff  <= mutex_count_in;
         row_vld_ff      <= row_vld_in;
         probe_vld_ff    <= probe_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         second_ff       <= second_in;
         marks_ff        <= marks_in;
      end
   end

   // a result never flags both a deadlock and a full table
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.deadlock && rsp_ch.overflow))
      else $error("deadlock and overflow flagged together");

   // a deadlock report leaves both tables empty
   a_clear_on_dl: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_dl_ff) |-> (thread_count_ff == '0 && mutex_count_ff == '0))
      else $error("tables not cleared after deadlock");

   // fill counts stay within their tables
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (thread_count_ff <= ldd_pkg::T_CNT_W'(ldd_pkg::MAX_THREADS)) &&
      (mutex_count_ff <= ldd_pkg::M_CNT_W'(ldd_pkg::MAX_MUTEXES)))
      else $error("table count beyond depth");

   // a row write always follows its own read
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMOD) |-> ($past(state_ff) == ST_EREAD))
      else $error("edge row written without a read");

endmodule

### tb/sv/ldd_checker.sv
// scoreboard for the lock graph deadlock detector: predicts each result and compares
// depends on ldd_pkg and the ldd_req_if / ldd_rsp_if channel interfaces
module ldd_checker (
   input  logic clock,
   input  logic reset,
   ldd_req_if   req_mon,
   ldd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic deadlock;
      logic overflow;
   } verdict_type;

   verdict_type                   verdicts_due[$];
   logic [ldd_pkg::ID_W-1:0]      known_threads[ldd_pkg::MAX_THREADS];
   logic [ldd_pkg::ID_W-1:0]      known_mutexes[ldd_pkg::MAX_MUTEXES];
   int                            n_threads;
   int                            n_mutexes;
   logic [ldd_pkg::NUM_VERTS-1:0] wait_arcs[ldd_pkg::NUM_VERTS];
   int                            rsp_seen;

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_seen   = 0;
   end

   function automatic void forget_all();
      n_threads = 0;
      n_mutexes = 0;
      for (int v = 0; v < ldd_pkg::NUM_VERTS; v++)
         wait_arcs[v] = '0;
   endfunction

   // follow the lowest outgoing arc from start; a revisit means a wait cycle
   function automatic bit closes_cycle(int start);
      logic [ldd_pkg::NUM_VERTS-1:0] seen;
      int                            cur;
      int                            nxt;
      seen        = '0;
      seen[start] = 1'b1;
      cur         = start;
      for (int hop = 0; hop <= ldd_pkg::NUM_VERTS; hop++) begin
         nxt = ldd_pkg::NUM_VERTS;
         for (int j = ldd_pkg::NUM_VERTS - 1; j >= 0; j--)
            if (wait_arcs[cur][j]) nxt = j;
         if (nxt == ldd_pkg::NUM_VERTS) return 1'b0;
         if (seen[nxt]) return 1'b1;
         seen[nxt] = 1'b1;
         cur       = nxt;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type apply_event(logic [ldd_pkg::OP_W-1:0] op,
                                               logic [ldd_pkg::ID_W-1:0] tid,
                                               logic [ldd_pkg::ID_W-1:0] addr);
      verdict_type v;
      int          ts;
      int          ms;
      int          tv;
      int          mv;
      v  = '0;
      ts = n_threads;
      for (int i = n_threads - 1; i >= 0; i--)
         if (known_threads[i] == tid) ts = i;
      ms = n_mutexes;
      for (int i = n_mutexes - 1; i >= 0; i--)
         if (known_mutexes[i] == addr) ms = i;
      // a new id with its table full leaves everything untouched
      if ((ts == n_threads && n_threads >= ldd_pkg::MAX_THREADS) ||
          (ms == n_mutexes && n_mutexes >= ldd_pkg::MAX_MUTEXES)) begin
         v.overflow = 1'b1;
         return v;
      end
      if (ts == n_threads) begin
         known_threads[ts] = tid;
         n_threads++;
      end
      if (ms == n_mutexes) begin
         known_mutexes[ms] = addr;
         n_mutexes++;
      end
      tv = ts;
      mv = ldd_pkg::MAX_THREADS + ms;
      case (op)
         ldd_pkg::OP_UNLOCK: wait_arcs[mv][tv] = 1'b0;
         ldd_pkg::OP_REQUEST: begin
            wait_arcs[tv][mv] = 1'b1;
            if (closes_cycle(tv)) begin
               v.deadlock = 1'b1;
               forget_all();
            end
         end
         default: begin
            // acquired, and the spare code behaves the same
            wait_arcs[tv][mv] = 1'b0;
            wait_arcs[mv][tv] = 1'b1;
         end
      endcase
      return v;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] result %0d: %s", $time, rsp_seen, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      verdict_type due;
      if (reset) begin
         verdicts_due.delete();
         forget_all();
      end else begin
         // pop before push: a result always belongs to an older item
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (verdicts_due.size() == 0) begin
               flag_mismatch("result with no item outstanding");
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_mon.deadlock !== due.deadlock)
                  flag_mismatch($sformatf("deadlock %b, predicted %b",
                                          rsp_mon.deadlock, due.deadlock));
               if (rsp_mon.overflow !== due.overflow)
                  flag_mismatch($sformatf("overflow %b, predicted %b",
                                          rsp_mon.overflow, due.overflow));
            end
            rsp_seen++;
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            verdicts_due.push_back(apply_event(req_mon.op, req_mon.thread_id,
                                               req_mon.mutex_addr));
      end
      pending = verdicts_due.size();
   end

endmodule

### tb/sv/tb_lock_graph_deadlock_detector.sv
// top of the lock graph deadlock detector testbench: clock, reset, stimulus, verdict
// depends on ldd_pkg, ldd_if, ldd_checker and the detector itself
module tb_lock_graph_deadlock_detector;
   timeunit 1ns;
   timeprecision 1ps;

   // unused op code, the block handles it like an acquire
   localparam logic [ldd_pkg::OP_W-1:0] OP_SPARE = 2'd3;
   // random items on top of the directed opening
   localparam int RANDOM_EVENTS = 1830;
   // pools a little larger than the tables so that overflow shows up
   localparam int POOL_MAX = 18;
   // run limit in ns; ~2000 items fit well inside this
   localparam int RUN_LIMIT_NS = 2_000_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   ldd_req_if req_ch ();
   ldd_rsp_if rsp_ch ();

   lock_graph_deadlock_detector dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ldd_checker audit (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // id pools that the random part draws from
   logic [ldd_pkg::ID_W-1:0] thr_pool[POOL_MAX];
   logic [ldd_pkg::ID_W-1:0] mux_pool[POOL_MAX];
   int                       thr_n;
   int                       mux_n;

   // sender and receiver side state
   int stall_left    = 0;
   int calm_rsp      = 0;
   int calm_req      = 0;
   int sent_n        = 0;
   bit last_deadlock = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("[lock_graph_deadlock_detector] ERROR");
      $finish;
   end

   // wait draw per item: mostly 0..11, now and then a run of back-to-back items
   function automatic int draw_pause(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // mostly full-width random ids, sometimes the all-zero and all-one extremes
   function automatic logic [ldd_pkg::ID_W-1:0] any_id();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [ldd_pkg::OP_W-1:0] acq_code();
      return ($urandom_range(0, 7) == 0) ? OP_SPARE : ldd_pkg::OP_ACQUIRED;
   endfunction

   task automatic fill_pools();
      thr_n = ($urandom_range(0, 3) == 0) ? POOL_MAX : $urandom_range(2, POOL_MAX);
      mux_n = ($urandom_range(0, 3) == 0) ? POOL_MAX : $urandom_range(2, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++) begin
         thr_pool[i] = any_id();
         mux_pool[i] = any_id();
      end
   endtask

   // one lock event: optional gap, then hold valid until the block takes it
   task automatic post_event(input logic [ldd_pkg::OP_W-1:0] op,
                             input logic [ldd_pkg::ID_W-1:0] tid,
                             input logic [ldd_pkg::ID_W-1:0] addr);
      int gap;
      gap = draw_pause(calm_req);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.thread_id  <= tid;
      req_ch.mutex_addr <= addr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent_n++;
   endtask

   // sender goes quiet until every outstanding result is back
   task automatic hold_until_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // result side: note each result, then pick the stall before the next one
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         last_deadlock = rsp_ch.deadlock;
         stall_left    = draw_pause(calm_rsp);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin : stimulus
      logic [ldd_pkg::ID_W-1:0] thr_a, thr_b, thr_c, mtx_a, mtx_b, mtx_c;
      int                       base;
      int                       k;
      int                       t0;
      int                       m0;
      int                       n;
      int                       pick;
      bit                       first_pass;
      logic [ldd_pkg::OP_W-1:0] op;
      logic [ldd_pkg::ID_W-1:0] tid;
      logic [ldd_pkg::ID_W-1:0] addr;

      reset             = 1'b1;
      rsp_ch.ready      = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.op         = ldd_pkg::OP_UNLOCK;
      req_ch.thread_id  = '0;
      req_ch.mutex_addr = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // extremes of the ids and the spare op code
      post_event(ldd_pkg::OP_UNLOCK, '0, '0);
      post_event(OP_SPARE, '1, '0);
      post_event(ldd_pkg::OP_ACQUIRED, '0, '1);
      // thread requests the mutex it already holds: self deadlock, tables clear
      post_event(ldd_pkg::OP_REQUEST, '0, '1);

      // cycle that the walk enters from outside: thr_a has two requests out and
      // only drops the lower one at the end, so thr_c runs into the loop
      thr_a = {$urandom(), $urandom()};
      thr_b = {$urandom(), $urandom()};
      thr_c = {$urandom(), $urandom()};
      mtx_a = {$urandom(), $urandom()};
      mtx_b = {$urandom(), $urandom()};
      mtx_c = {$urandom(), $urandom()};
      post_event(ldd_pkg::OP_REQUEST, thr_a, mtx_a);
      post_event(ldd_pkg::OP_ACQUIRED, thr_b, mtx_b);
      post_event(ldd_pkg::OP_REQUEST, thr_a, mtx_b);
      post_event(ldd_pkg::OP_ACQUIRED, thr_a, mtx_c);
      post_event(ldd_pkg::OP_REQUEST, thr_b, mtx_c);
      post_event(ldd_pkg::OP_ACQUIRED, thr_a, mtx_a);
      post_event(ldd_pkg::OP_REQUEST, thr_c, mtx_b);

      // classic two-thread crossing
      post_event(ldd_pkg::OP_ACQUIRED, thr_a, mtx_a);
      post_event(ldd_pkg::OP_ACQUIRED, thr_b, mtx_b);
      post_event(ldd_pkg::OP_REQUEST, thr_a, mtx_b);
      post_event(ldd_pkg::OP_REQUEST, thr_b, mtx_a);

      // unlock drops the holder arc; unlock of an arc that is not there
      post_event(ldd_pkg::OP_ACQUIRED, thr_c, mtx_c);
      post_event(ldd_pkg::OP_UNLOCK, thr_c, mtx_c);
      post_event(ldd_pkg::OP_REQUEST, thr_c, mtx_c);
      post_event(ldd_pkg::OP_UNLOCK, thr_b, mtx_c);

      hold_until_idle();
      base       = sent_n;
      first_pass = 1'b1;
      fill_pools();

      // random part: well-formed wait chains with random members, plus noise
      while (sent_n - base < RANDOM_EVENTS) begin
         if ($urandom_range(0, 9) < 6) begin
            // each thread takes one mutex, then asks for its neighbor's
            k = $urandom_range(1, 4);
            if (k > thr_n) k = thr_n;
            if (k > mux_n) k = mux_n;
            t0 = $urandom_range(0, thr_n - 1);
            m0 = $urandom_range(0, mux_n - 1);
            for (int i = 0; i < k; i++)
               if ($urandom_range(0, 9) != 0)
                  post_event(acq_code(), thr_pool[(t0 + i) % thr_n],
                             mux_pool[(m0 + i) % mux_n]);
            for (int i = 0; i < k; i++) begin
               // an occasional early unlock breaks the chain
               if ($urandom_range(0, 15) == 0)
                  post_event(ldd_pkg::OP_UNLOCK, thr_pool[(t0 + i) % thr_n],
                             mux_pool[(m0 + i) % mux_n]);
               post_event(ldd_pkg::OP_REQUEST, thr_pool[(t0 + i) % thr_n],
                          mux_pool[(m0 + (i + 1) % k) % mux_n]);
            end
         end else begin
            // loose events, now and then with an id from outside the pool
            n = $urandom_range(5, 25);
            for (int i = 0; i < n; i++) begin
               pick = $urandom_range(0, 19);
               if (pick < 6)       op = ldd_pkg::OP_UNLOCK;
               else if (pick < 13) op = ldd_pkg::OP_REQUEST;
               else                op = acq_code();
               tid  = ($urandom_range(0, 19) == 0) ? any_id()
                                                   : thr_pool[$urandom_range(0, thr_n - 1)];
               addr = ($urandom_range(0, 19) == 0) ? any_id()
                                                   : mux_pool[$urandom_range(0, mux_n - 1)];
               post_event(op, tid, addr);
            end
         end
         // drain now and then; fresh pools only when the tables are known empty
         if (first_pass || $urandom_range(0, 3) == 0) begin
            hold_until_idle();
            if (last_deadlock) fill_pools();
            first_pass = 1'b0;
         end
      end

      hold_until_idle();
      // room for any stray result after the last one predicted
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[lock_graph_deadlock_detector] OK");
      else
         $display("[lock_graph_deadlock_detector] ERROR");
      $finish;
   end

endmodule
